### hw/rtl/elht_pkg.sv
// ============================================================================
// elht_pkg
// Shared types and constants of the endpoint load and health tracker.
// ============================================================================
package elht_pkg;

    // Fixed field widths
    localparam int unsigned BYTES_W = 64;
    localparam int unsigned FRAC_W  = 17;
    localparam int unsigned RUN_W   = 16;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PROD_W  = 34;
    localparam int unsigned DIV_STEPS_W = 4;

    // Q1.16 one and streak ceiling
    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [RUN_W-1:0]  RUN_MAX = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAK_LIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EWMA_ALPHA = 2'd2;

    // Configuration reset values
    localparam logic [BYTES_W-1:0] SATURATION_RST = 64'd67108864;
    localparam logic [RUN_W-1:0]   STREAK_LIM_RST = 16'd3;
    localparam logic [FRAC_W-1:0]  EWMA_ALPHA_RST = 17'd6554;

    // Health classes
    localparam logic [1:0] HEALTH_OK        = 2'd0;
    localparam logic [1:0] HEALTH_DEGRADED  = 2'd1;
    localparam logic [1:0] HEALTH_UNHEALTHY = 2'd2;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_FINISH  = 2'd1,
        OP_OBSERVE = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                opcode;
        logic [INDEX_W-1:0] endpoint_index;
        logic [BYTES_W-1:0] byte_count;
        logic               health_counted;
        logic               has_outcome;
        logic               outcome_ok;
    } req_t;

    typedef struct packed {
        logic               entry_known;
        logic [BYTES_W-1:0] queued_total;
        logic [FRAC_W-1:0]  load_fraction;
        logic [1:0]         health_class;
        logic [FRAC_W-1:0]  health_cost;
        logic               busy_start;
    } rsp_t;

    // One tracker table entry
    typedef struct packed {
        logic               valid;
        logic               seen;
        logic [RUN_W-1:0]   run;
        logic [FRAC_W-1:0]  avg;
        logic [BYTES_W-1:0] queued;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_AVERAGE,
        ST_WRITE,
        ST_DIVIDE,
        ST_RESPOND
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic capture;
        logic read;
        logic update;
        logic average;
        logic write;
        logic divide;
        logic respond;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic div_last;
    } sts_t;

endpackage

### hw/rtl/elht_ram.sv
// ============================================================================
// elht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module elht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/elht_ctrl.sv
// ============================================================================
// elht_ctrl
// Sequencer: clear sweep, then read, update, average, write back, divide and respond per item.
// ============================================================================
module elht_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  elht_pkg::sts_t sts,
    output elht_pkg::ctl_t ctl
);

    elht_pkg::state_t state_reg;
    elht_pkg::state_t state_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             rsp_free;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            elht_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = elht_pkg::ST_IDLE;
                end
            end
            elht_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = elht_pkg::ST_READ;
                end
            end
            elht_pkg::ST_READ:    state_next = elht_pkg::ST_UPDATE;
            elht_pkg::ST_UPDATE:  state_next = elht_pkg::ST_AVERAGE;
            elht_pkg::ST_AVERAGE: state_next = elht_pkg::ST_WRITE;
            elht_pkg::ST_WRITE:   state_next = elht_pkg::ST_DIVIDE;
            elht_pkg::ST_DIVIDE:
            begin
                if (sts.div_last)
                begin
                    state_next = elht_pkg::ST_RESPOND;
                end
            end
            elht_pkg::ST_RESPOND:
            begin
                if (rsp_free)
                begin
                    state_next = elht_pkg::ST_IDLE;
                end
            end
            default: state_next = elht_pkg::ST_CLEAR;
        endcase
    end

    // Commands
    always_comb
    begin
        ctl       = '0;
        req_stall = 1'b1;
        case (state_reg)
            elht_pkg::ST_CLEAR:   ctl.clear = 1'b1;
            elht_pkg::ST_IDLE:
            begin
                req_stall   = 1'b0;
                ctl.capture = req_valid;
            end
            elht_pkg::ST_READ:    ctl.read    = 1'b1;
            elht_pkg::ST_UPDATE:  ctl.update  = 1'b1;
            elht_pkg::ST_AVERAGE: ctl.average = 1'b1;
            elht_pkg::ST_WRITE:   ctl.write   = 1'b1;
            elht_pkg::ST_DIVIDE:  ctl.divide  = 1'b1;
            elht_pkg::ST_RESPOND: ctl.respond = rsp_free;
            default:              ctl         = '0;
        endcase
    end

    // Hold the result until the receiver takes it
    assign rsp_valid_next = ctl.respond | (rsp_valid_reg & rsp_stall);
    assign rsp_valid      = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= elht_pkg::ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### hw/rtl/elht_dpath.sv
// ============================================================================
// elht_dpath
// Tracker table, configuration registers, EWMA unit and load divider.
// ============================================================================
module elht_dpath #(
    parameter int ENDPOINTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  elht_pkg::ctl_t                      ctl,
    output elht_pkg::sts_t                      sts,
    input  elht_pkg::req_t                      req_data,
    output elht_pkg::rsp_t                      rsp_data,
    input  logic                                cfg_valid,
    input  logic [elht_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [elht_pkg::CFG_W-1:0]          cfg_data
);

    localparam int IDX_W = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
    localparam int ENT_W = $bits(elht_pkg::entry_t);

    // Configuration
    logic [elht_pkg::BYTES_W-1:0] sat_reg;
    logic [elht_pkg::RUN_W-1:0]   limit_reg;
    logic [elht_pkg::FRAC_W-1:0]  alpha_reg;

    // Working registers
    elht_pkg::req_t               req_reg;
    elht_pkg::entry_t             ent_reg;
    elht_pkg::entry_t             ent_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         go_reg;
    logic                         go_next;
    logic [elht_pkg::PROD_W-1:0]  prod_reg;
    logic [elht_pkg::PROD_W-1:0]  prod_next;
    logic [IDX_W-1:0]             clr_reg;
    logic [elht_pkg::BYTES_W-1:0] rem_reg;
    logic [elht_pkg::BYTES_W-1:0] rem_next;
    logic [15:0]                  quo_reg;
    logic [15:0]                  quo_next;
    logic [elht_pkg::DIV_STEPS_W-1:0] cnt_reg;
    logic                         sat_hit_reg;
    elht_pkg::rsp_t               rsp_reg;
    elht_pkg::rsp_t               rsp_next;

    // Table port signals
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ENT_W-1:0]             ram_wdata;
    logic [ENT_W-1:0]             ram_rdata;
    elht_pkg::entry_t             rd_ent;
    logic [IDX_W-1:0]             idx;
    logic                         in_range;

    // Arithmetic helpers
    logic [elht_pkg::BYTES_W:0]   sum;
    logic [elht_pkg::FRAC_W-1:0]  alpha_eff;
    logic [elht_pkg::FRAC_W-1:0]  diff;
    logic [elht_pkg::PROD_W-1:0]  prod_round;
    logic [elht_pkg::FRAC_W:0]    avg_wide;
    logic [elht_pkg::BYTES_W-1:0] sat_eff;
    logic [elht_pkg::BYTES_W:0]   rem_dbl;

    assign idx      = IDX_W'(req_reg.endpoint_index);
    assign in_range = 32'(req_reg.endpoint_index) < ENDPOINTS;
    assign rd_ent   = elht_pkg::entry_t'(ram_rdata);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg   <= elht_pkg::SATURATION_RST;
            limit_reg <= elht_pkg::STREAK_LIM_RST;
            alpha_reg <= elht_pkg::EWMA_ALPHA_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                elht_pkg::CFG_SATURATION: sat_reg   <= cfg_data;
                elht_pkg::CFG_STREAK_LIM: limit_reg <= cfg_data[elht_pkg::RUN_W-1:0];
                elht_pkg::CFG_EWMA_ALPHA: alpha_reg <= cfg_data[elht_pkg::FRAC_W-1:0];
                default:                  sat_reg   <= sat_reg;
            endcase
        end
    end

    // Clear sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctl.clear)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign sts.clr_last = (clr_reg == IDX_W'(ENDPOINTS - 1));
    assign sts.div_last = (cnt_reg == '1);

    // Table write: zeros during the sweep, the updated entry otherwise
    assign ram_we    = ctl.clear | (ctl.write & in_range);
    assign ram_waddr = ctl.clear ? clr_reg : idx;
    assign ram_wdata = ctl.clear ? '0 : ENT_W'(ent_reg);

    elht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENDPOINTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ctl.read),
        .rd_addr (idx),
        .rd_data (ram_rdata)
    );

    // Latch the transaction
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= req_data;
        end
    end

    // Apply the operation to the fetched entry and form the EWMA product; then take the EWMA step
    always_comb
    begin
        ent_next  = ent_reg;
        busy_next = busy_reg;
        go_next   = go_reg;
        sum       = {1'b0, rd_ent.queued} + {1'b0, req_reg.byte_count};
        alpha_eff = (alpha_reg > elht_pkg::ONE_Q16) ? elht_pkg::ONE_Q16 : alpha_reg;
        diff      = req_reg.outcome_ok ? rd_ent.avg : (elht_pkg::ONE_Q16 - rd_ent.avg);
        prod_next = {{(elht_pkg::PROD_W - elht_pkg::FRAC_W){1'b0}}, alpha_eff}
                  * {{(elht_pkg::PROD_W - elht_pkg::FRAC_W){1'b0}}, diff};
        prod_round = prod_reg + elht_pkg::PROD_W'(65535);
        avg_wide   = '0;
        if (ctl.update)
        begin
            ent_next  = rd_ent;
            busy_next = 1'b0;
            go_next   = 1'b0;
            case (req_reg.opcode)
                elht_pkg::OP_RESERVE:
                begin
                    if (req_reg.byte_count != '0)
                    begin
                        ent_next.valid  = 1'b1;
                        busy_next       = (rd_ent.queued == '0);
                        ent_next.queued = sum[elht_pkg::BYTES_W] ? '1
                                        : sum[elht_pkg::BYTES_W-1:0];
                    end
                end
                elht_pkg::OP_FINISH:
                begin
                    if (rd_ent.valid)
                    begin
                        ent_next.queued = (req_reg.byte_count >= rd_ent.queued) ? '0
                                        : rd_ent.queued - req_reg.byte_count;
                        go_next = req_reg.health_counted & req_reg.has_outcome;
                    end
                end
                elht_pkg::OP_OBSERVE: ent_next.valid = 1'b1;
                elht_pkg::OP_QUERY:   ent_next.valid = rd_ent.valid;
                default:              ent_next       = rd_ent;
            endcase
        end
        else if (ctl.average && go_reg)
        begin
            // First sample loads directly; later ones move by the scaled gap
            if (!ent_reg.seen)
            begin
                avg_wide = req_reg.outcome_ok ? '0 : {1'b0, elht_pkg::ONE_Q16};
            end
            else if (req_reg.outcome_ok)
            begin
                avg_wide = {1'b0, ent_reg.avg} - prod_round[elht_pkg::PROD_W-1:16];
            end
            else
            begin
                avg_wide = {1'b0, ent_reg.avg} + prod_reg[elht_pkg::PROD_W-1:16];
            end
            ent_next.avg = (avg_wide > {1'b0, elht_pkg::ONE_Q16}) ? elht_pkg::ONE_Q16
                         : avg_wide[elht_pkg::FRAC_W-1:0];
            ent_next.seen = 1'b1;
            if (req_reg.outcome_ok)
            begin
                ent_next.run = '0;
            end
            else if (ent_reg.run != elht_pkg::RUN_MAX)
            begin
                ent_next.run = ent_reg.run + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        busy_reg <= busy_next;
        go_reg   <= go_next;
        if (ctl.update)
        begin
            prod_reg <= prod_next;
        end
    end

    // Load fraction: restoring divide, one quotient bit per cycle
    assign sat_eff = (sat_reg == '0) ? elht_pkg::BYTES_W'(1) : sat_reg;
    assign rem_dbl = {rem_reg, 1'b0};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ctl.write)
        begin
            rem_next = ent_reg.queued;
            quo_next = '0;
        end
        else if (ctl.divide)
        begin
            if (rem_dbl >= {1'b0, sat_eff})
            begin
                rem_next = rem_dbl[elht_pkg::BYTES_W-1:0] - sat_eff;
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = rem_dbl[elht_pkg::BYTES_W-1:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (ctl.write)
        begin
            sat_hit_reg <= (ent_reg.queued >= sat_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.write)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.divide)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Build the result from the final entry
    always_comb
    begin
        rsp_next = '0;
        if (ent_reg.valid && in_range)
        begin
            rsp_next.entry_known   = 1'b1;
            rsp_next.queued_total  = ent_reg.queued;
            rsp_next.load_fraction = sat_hit_reg ? elht_pkg::ONE_Q16 : {1'b0, quo_reg};
            rsp_next.busy_start    = busy_reg;
            rsp_next.health_cost   = ent_reg.avg;
            if (ent_reg.run >= limit_reg)
            begin
                rsp_next.health_class = elht_pkg::HEALTH_UNHEALTHY;
                rsp_next.health_cost  = elht_pkg::ONE_Q16;
            end
            else if (ent_reg.run != '0 || ent_reg.avg != '0)
            begin
                rsp_next.health_class = elht_pkg::HEALTH_DEGRADED;
            end
            else
            begin
                rsp_next.health_class = elht_pkg::HEALTH_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.respond)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

### hw/rtl/endpoint_load_health_tracker.sv
// ============================================================================
// endpoint_load_health_tracker
// Per-endpoint queued-byte, load and failure-health tracker.
// ============================================================================
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one operation:
//   reserve, finish, observe or query on one endpoint slot. rsp channel
//   (rsp_valid/rsp_stall/rsp_data) returns exactly one result per request:
//   the slot's queued bytes, load fraction, health class and cost.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes saturation
//   bytes, streak limit and EWMA alpha; write only while no request is open.
//   Sequence: an accepted request passes a table read, an update, an EWMA
//   step, a table write and the 16-step load-fraction divider, one quotient
//   bit a cycle, before its result is offered. No new request is taken until
//   the current one's result has been loaded into the output register.
//   Reset: a clearing pass writes every slot to zero in turn, with
//   req_stall high; configuration returns to its reset values at once.
//   A stalled result is held in the output register; the next request is
//   still accepted and processed, and waits at the end until the slot frees.
// ============================================================================
module endpoint_load_health_tracker #(
    parameter int ENDPOINTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  elht_pkg::req_t                    req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output elht_pkg::rsp_t                    rsp_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [elht_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [elht_pkg::CFG_W-1:0]        cfg_data
);

    elht_pkg::ctl_t ctl;
    elht_pkg::sts_t sts;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    elht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    elht_dpath #(
        .ENDPOINTS (ENDPOINTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .req_data  (req_data),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### hw/rtl/elht_checker.sv
// ============================================================================
// elht_checker
// Port-level checks of the endpoint load and health tracker.
// ============================================================================
module elht_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input elht_pkg::rsp_t rsp_data
);

    // Stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // Stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_data))
        else $error("result changed while stalled");

    // One transaction at a time: accept closes the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while one is in flight");

    // Unknown slot reports all fields zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.entry_known |->
            rsp_data.queued_total == '0 && rsp_data.load_fraction == '0 &&
            rsp_data.health_class == elht_pkg::HEALTH_OK &&
            rsp_data.health_cost == '0 && !rsp_data.busy_start)
        else $error("unknown slot with nonzero fields");

    // Unhealthy forces full cost; fraction never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
            (rsp_data.health_class != elht_pkg::HEALTH_UNHEALTHY ||
             rsp_data.health_cost == elht_pkg::ONE_Q16) &&
            rsp_data.load_fraction <= elht_pkg::ONE_Q16)
        else $error("cost or load fraction out of range");

endmodule

bind endpoint_load_health_tracker elht_checker u_elht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

### verif/tb.sv
// ============================================================================
// tb
// Testbench of the endpoint load and health tracker. A predictor keeps its own
// copy of the slot table and registers and computes the expected status for
// each request transaction. A monitor compares every response transaction
// field by field, in order. Both channels idle at random. The stimulus runs
// a directed part, sweeps the registers through their extremes, pauses
// until the block drains, and finishes with random traffic.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS       = 64;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_SHOWN     = 10;

    // Register index with no register behind it
    localparam logic [elht_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    elht_pkg::req_t                 req_data;
    logic                           rsp_valid;
    logic                           rsp_stall;
    elht_pkg::rsp_t                 rsp_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [elht_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [elht_pkg::CFG_W-1:0]     cfg_data;

    endpoint_load_health_tracker #(
        .ENDPOINTS (N_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted slot table and registers
    logic                         trk_valid  [N_SLOTS];
    logic [elht_pkg::BYTES_W-1:0] trk_queued [N_SLOTS];
    logic [elht_pkg::FRAC_W-1:0]  trk_avg    [N_SLOTS];
    logic                         trk_seen   [N_SLOTS];
    logic [elht_pkg::RUN_W-1:0]   trk_run    [N_SLOTS];
    logic [elht_pkg::BYTES_W-1:0] cur_saturation;
    logic [elht_pkg::RUN_W-1:0]   cur_streak_lim;
    logic [elht_pkg::FRAC_W-1:0]  cur_alpha;

    elht_pkg::rsp_t status_q[$];
    int   mismatches  = 0;
    int   idle_cycles = 0;
    int   burst_left  = 0;
    int   fail_pct    = 40;

    // Clear the predicted table and restore register defaults
    function automatic void reset_tracker();
        for (int i = 0; i < N_SLOTS; i++)
        begin
            trk_valid[i]  = 1'b0;
            trk_queued[i] = '0;
            trk_avg[i]    = '0;
            trk_seen[i]   = 1'b0;
            trk_run[i]    = '0;
        end
        cur_saturation = elht_pkg::SATURATION_RST;
        cur_streak_lim = elht_pkg::STREAK_LIM_RST;
        cur_alpha      = elht_pkg::EWMA_ALPHA_RST;
    endfunction

    function automatic void apply_register(logic [elht_pkg::CFG_IDX_W-1:0] idx,
                                           logic [elht_pkg::CFG_W-1:0] val);
        case (idx)
            elht_pkg::CFG_SATURATION: cur_saturation = val;
            elht_pkg::CFG_STREAK_LIM: cur_streak_lim = val[elht_pkg::RUN_W-1:0];
            elht_pkg::CFG_EWMA_ALPHA: cur_alpha      = val[elht_pkg::FRAC_W-1:0];
            default: ;
        endcase
    endfunction

    // Load fraction: floor(q * 2^16 / saturation), capped at one
    function automatic logic [elht_pkg::FRAC_W-1:0] load_of(
        logic [elht_pkg::BYTES_W-1:0] q);
        logic [elht_pkg::BYTES_W-1:0] s;
        logic [79:0]                  quot;
        s = (cur_saturation == '0) ? 64'd1 : cur_saturation;
        if (q >= s)
            return elht_pkg::ONE_Q16;
        quot = {q, 16'h0000} / {16'h0000, s};
        return quot[elht_pkg::FRAC_W-1:0];
    endfunction

    // Fold one counted outcome into the failure average and streak
    function automatic void fold_outcome(int k, logic ok);
        logic [elht_pkg::FRAC_W-1:0] sample;
        logic [elht_pkg::FRAC_W-1:0] a;
        logic [elht_pkg::FRAC_W:0]   avg;
        logic [33:0]                 prod;
        sample = ok ? '0 : elht_pkg::ONE_Q16;
        a      = (cur_alpha > elht_pkg::ONE_Q16) ? elht_pkg::ONE_Q16 : cur_alpha;
        avg    = {1'b0, trk_avg[k]};
        if (!trk_seen[k])
            avg = {1'b0, sample};
        else if (sample >= trk_avg[k])
        begin
            prod = {17'd0, a} * {17'd0, sample - trk_avg[k]};
            avg  = avg + prod[33:16];
        end
        else
        begin
            // round the step up so the average floors toward minus infinity
            prod = {17'd0, a} * {17'd0, trk_avg[k] - sample};
            prod = prod + 34'd65535;
            avg  = avg - prod[33:16];
        end
        if (avg > {1'b0, elht_pkg::ONE_Q16})
            avg = {1'b0, elht_pkg::ONE_Q16};
        trk_avg[k]  = avg[elht_pkg::FRAC_W-1:0];
        trk_seen[k] = 1'b1;
        if (ok)
            trk_run[k] = '0;
        else if (trk_run[k] != elht_pkg::RUN_MAX)
            trk_run[k] = trk_run[k] + 1'b1;
    endfunction

    // Apply one operation to the predicted table and build its status
    function automatic elht_pkg::rsp_t track_step(elht_pkg::req_t r);
        elht_pkg::rsp_t                res;
        int                            k;
        logic                          busy;
        logic [elht_pkg::BYTES_W:0]    sum;
        res  = '0;
        busy = 1'b0;
        k    = int'(r.endpoint_index);
        case (r.opcode)
            elht_pkg::OP_RESERVE:
            begin
                if (r.byte_count != '0)
                begin
                    busy          = (trk_queued[k] == '0);
                    trk_valid[k]  = 1'b1;
                    sum           = {1'b0, trk_queued[k]} + {1'b0, r.byte_count};
                    trk_queued[k] = sum[elht_pkg::BYTES_W] ? '1
                                  : sum[elht_pkg::BYTES_W-1:0];
                end
            end
            elht_pkg::OP_FINISH:
            begin
                if (trk_valid[k])
                begin
                    trk_queued[k] = (r.byte_count >= trk_queued[k]) ? '0
                                  : trk_queued[k] - r.byte_count;
                    if (r.health_counted && r.has_outcome)
                        fold_outcome(k, r.outcome_ok);
                end
            end
            elht_pkg::OP_OBSERVE: trk_valid[k] = 1'b1;
            default: ;
        endcase
        if (!trk_valid[k])
            return res;
        res.entry_known   = 1'b1;
        res.queued_total  = trk_queued[k];
        res.load_fraction = load_of(trk_queued[k]);
        res.busy_start    = busy;
        res.health_cost   = trk_avg[k];
        if (trk_run[k] >= cur_streak_lim)
        begin
            res.health_class = elht_pkg::HEALTH_UNHEALTHY;
            res.health_cost  = elht_pkg::ONE_Q16;
        end
        else if (trk_run[k] != '0 || trk_avg[k] != '0)
            res.health_class = elht_pkg::HEALTH_DEGRADED;
        else
            res.health_class = elht_pkg::HEALTH_OK;
        return res;
    endfunction

    function automatic void cmp_field(string fname, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("mismatch at %0t: %s expected %0h got %0h", $time, fname, want, got);
        end
    endfunction

    // Compare one response transaction with the oldest predicted status
    function automatic void check_status(elht_pkg::rsp_t got);
        elht_pkg::rsp_t want;
        if (status_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("mismatch at %0t: response with no request pending", $time);
            return;
        end
        want = status_q.pop_front();
        cmp_field("entry_known", 64'(want.entry_known), 64'(got.entry_known));
        cmp_field("queued_total", want.queued_total, got.queued_total);
        cmp_field("load_fraction", 64'(want.load_fraction), 64'(got.load_fraction));
        cmp_field("health_class", 64'(want.health_class), 64'(got.health_class));
        cmp_field("health_cost", 64'(want.health_cost), 64'(got.health_cost));
        cmp_field("busy_start", 64'(want.busy_start), 64'(got.busy_start));
    endfunction

    // Monitor: check responses, track register writes, predict requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                check_status(rsp_data);
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (req_valid && !req_stall)
                status_q.push_back(track_step(req_data));
        end
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: errors");
        $finish;
    end

    // Response stall: short and long stalls, with free-running stretches
    initial
    begin : rsp_stall_drive
        int   r;
        int   len;
        logic on;
        rsp_stall = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                on  = 1'b0;
                len = $urandom_range(1, 6);
            end
            else if (r < 65)
            begin
                on  = 1'b0;
                len = $urandom_range(30, 120);
            end
            else if (r < 95)
            begin
                on  = 1'b1;
                len = $urandom_range(1, 4);
            end
            else
            begin
                on  = 1'b1;
                len = $urandom_range(15, 60);
            end
            @(negedge clk);
            rsp_stall = on;
            repeat (len - 1) @(negedge clk);
        end
    end

    // Sender gap: mostly none or short, a few long, now and then a burst
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Send one request transaction and hold it until accepted
    task automatic send_op(elht_pkg::req_t r);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_data  = r;
        req_valid = 1'b1;
        do @(posedge clk); while (req_stall);
    endtask

    // Drop valid and wait until every predicted status has come back
    task automatic settle();
        @(negedge clk);
        req_valid = 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [elht_pkg::CFG_IDX_W-1:0] idx,
                             logic [elht_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(logic [elht_pkg::CFG_W-1:0] sat,
                             logic [elht_pkg::CFG_W-1:0] lim,
                             logic [elht_pkg::CFG_W-1:0] alpha);
        settle();
        write_reg(elht_pkg::CFG_SATURATION, sat);
        write_reg(elht_pkg::CFG_STREAK_LIM, lim);
        write_reg(elht_pkg::CFG_EWMA_ALPHA, alpha);
    endtask

    function automatic elht_pkg::req_t mk_op(elht_pkg::op_t op, int k,
                                             logic [elht_pkg::BYTES_W-1:0] b,
                                             logic counted, logic has, logic ok);
        elht_pkg::req_t r;
        r.opcode         = op;
        r.endpoint_index = k[elht_pkg::INDEX_W-1:0];
        r.byte_count     = b;
        r.health_counted = counted;
        r.has_outcome    = has;
        r.outcome_ok     = ok;
        return r;
    endfunction

    function automatic logic chance(int pct);
        return ($urandom_range(0, 99) < pct);
    endfunction

    // Mostly a hot set of slots so state builds up, sometimes any slot
    function automatic int pick_slot();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 7);
        return $urandom_range(0, N_SLOTS - 1);
    endfunction

    // Byte counts scaled around the current saturation point
    function automatic logic [elht_pkg::BYTES_W-1:0] pick_bytes();
        logic [elht_pkg::BYTES_W-1:0] s;
        s = (cur_saturation == '0) ? 64'd1 : cur_saturation;
        case ($urandom_range(0, 19))
            0:             return '0;
            1, 2:          return '1;
            3, 4, 5:       return {$urandom, $urandom};
            6, 7, 8, 9:    return 64'($urandom_range(1, 4096));
            10, 11, 12, 13: return (s >> $urandom_range(1, 12)) + 64'($urandom_range(0, 3));
            14, 15:        return s + 64'($urandom_range(0, 2)) - 64'd1;
            default:       return 64'($urandom);
        endcase
    endfunction

    function automatic elht_pkg::req_t random_op();
        elht_pkg::op_t op;
        op = elht_pkg::op_t'($urandom_range(0, 3));
        if (op == elht_pkg::OP_FINISH)
            return mk_op(op, pick_slot(), pick_bytes(), chance(80), chance(80),
                         chance(100 - fail_pct));
        return mk_op(op, pick_slot(), pick_bytes(), chance(50), chance(50), chance(50));
    endfunction

    // Mostly reserve/finish pairs on one slot, the rest single random ops
    task automatic run_transfers(int count);
        int                           sent;
        int                           k;
        logic [elht_pkg::BYTES_W-1:0] b;
        sent = 0;
        while (sent < count)
        begin
            if (chance(55))
            begin
                k = pick_slot();
                b = pick_bytes();
                send_op(mk_op(elht_pkg::OP_RESERVE, k, b, chance(50), chance(50),
                              chance(50)));
                if (chance(25))
                begin
                    send_op(mk_op(elht_pkg::OP_QUERY, k, {$urandom, $urandom},
                                  chance(50), chance(50), chance(50)));
                    sent++;
                end
                // release part of the reservation now and then
                if (chance(20))
                    b = b >> $urandom_range(1, 8);
                send_op(mk_op(elht_pkg::OP_FINISH, k, b, chance(90), chance(90),
                              chance(100 - fail_pct)));
                sent += 2;
            end
            else
            begin
                send_op(random_op());
                sent++;
            end
        end
    endtask

    // Special cases and field extremes at reset register values
    task automatic test_directed();
        send_op(mk_op(elht_pkg::OP_QUERY,   0, '0, 1'b0, 1'b0, 1'b0));
        // finish and zero reserve on never-created slots are ignored
        send_op(mk_op(elht_pkg::OP_FINISH,  1, 64'd100, 1'b1, 1'b1, 1'b0));
        send_op(mk_op(elht_pkg::OP_RESERVE, 2, '0, 1'b1, 1'b1, 1'b1));
        send_op(mk_op(elht_pkg::OP_QUERY,   2, '1, 1'b1, 1'b1, 1'b1));
        send_op(mk_op(elht_pkg::OP_OBSERVE, 3, '0, 1'b0, 1'b0, 1'b0));
        // queued bytes saturate, then floor at zero
        send_op(mk_op(elht_pkg::OP_RESERVE, 4, 64'd1, 1'b0, 1'b0, 1'b0));
        send_op(mk_op(elht_pkg::OP_RESERVE, 4, '1, 1'b0, 1'b0, 1'b0));
        send_op(mk_op(elht_pkg::OP_FINISH,  4, 64'd5, 1'b0, 1'b1, 1'b0));
        send_op(mk_op(elht_pkg::OP_FINISH,  4, '1, 1'b1, 1'b0, 1'b0));
        send_op(mk_op(elht_pkg::OP_RESERVE, 4, elht_pkg::SATURATION_RST, 1'b0, 1'b0, 1'b0));
        send_op(mk_op(elht_pkg::OP_FINISH,  4, 64'd1, 1'b0, 1'b0, 1'b0));
        // first success, then failures up to the streak limit, then recovery
        send_op(mk_op(elht_pkg::OP_FINISH,  3, '0, 1'b1, 1'b1, 1'b1));
        send_op(mk_op(elht_pkg::OP_FINISH,  3, '0, 1'b1, 1'b1, 1'b0));
        send_op(mk_op(elht_pkg::OP_FINISH,  3, '0, 1'b1, 1'b1, 1'b0));
        send_op(mk_op(elht_pkg::OP_FINISH,  3, '0, 1'b1, 1'b1, 1'b0));
        send_op(mk_op(elht_pkg::OP_QUERY,   3, '0, 1'b0, 1'b0, 1'b0));
        send_op(mk_op(elht_pkg::OP_FINISH,  3, '0, 1'b1, 1'b1, 1'b1));
        send_op(mk_op(elht_pkg::OP_RESERVE, 63, {$urandom, $urandom} | 64'd1,
                      1'b1, 1'b1, 1'b1));
        send_op(mk_op(elht_pkg::OP_FINISH,  63, 64'd7, 1'b0, 1'b1, 1'b0));
        // first sample a failure loads the average at one
        send_op(mk_op(elht_pkg::OP_RESERVE, 6, 64'd1, 1'b0, 1'b0, 1'b0));
        send_op(mk_op(elht_pkg::OP_FINISH,  6, 64'd1, 1'b1, 1'b1, 1'b0));
        send_op(mk_op(elht_pkg::OP_FINISH,  6, '0, 1'b1, 1'b1, 1'b1));
        send_op(mk_op(elht_pkg::OP_RESERVE, 7, '1, 1'b1, 1'b1, 1'b1));
        send_op(mk_op(elht_pkg::OP_QUERY,   7, '1, 1'b1, 1'b1, 1'b1));
    endtask

    // Sweep the registers through extremes and out-of-range encodings
    task automatic test_config_sweep();
        fail_pct = 50;
        write_all(64'd1, 64'd1, 64'd65536);
        run_transfers(90);
        write_all('1, 64'd65535, 64'd1);
        run_transfers(90);
        // zero saturation acts as one, zero limit marks every known slot unhealthy,
        // zero alpha freezes the average after its first sample
        write_all('0, '0, '0);
        run_transfers(90);
        fail_pct = 70;
        write_all(64'd4096, {$urandom, 16'hABCD, 16'd2}, {$urandom, 15'h5A5A, 17'h1FFFF});
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        run_transfers(90);
        fail_pct = 40;
        write_all({$urandom, $urandom}, 64'($urandom_range(1, 8)),
                  64'($urandom_range(1, 65536)));
        run_transfers(90);
        write_all(elht_pkg::SATURATION_RST, 64'(elht_pkg::STREAK_LIM_RST),
                  64'(elht_pkg::EWMA_ALPHA_RST));
        run_transfers(90);
    endtask

    // Hold the sender until every pending status has arrived, then resume
    task automatic test_hold_until_drained();
        run_transfers(30);
        settle();
        run_transfers(30);
    endtask

    // Random settings, random failure mix
    task automatic test_random_mix();
        logic [elht_pkg::CFG_W-1:0] sat;
        logic [elht_pkg::CFG_W-1:0] lim;
        for (int phase = 0; phase < 5; phase++)
        begin
            case ($urandom_range(0, 2))
                0:       sat = {$urandom, $urandom};
                1:       sat = 64'($urandom_range(1, 100000));
                default: sat = 64'd1 << $urandom_range(0, 63);
            endcase
            lim      = chance(80) ? 64'($urandom_range(1, 6)) : 64'd65535;
            fail_pct = $urandom_range(20, 80);
            write_all(sat, lim, 64'($urandom_range(1, 65536)));
            run_transfers(100);
        end
    endtask

    initial
    begin : stimulus
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_tracker();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_sweep();
        test_hold_until_drained();
        test_random_mix();
        settle();

        if (mismatches == 0 && status_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
